### hdl/assert_macros.svh
// Assertion macros for the checker module of the Speck48/72 core.
// Depends on nothing; the including module must provide clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/spk48_pkg.sv
// Package for the Speck48/72 core: word widths, payload types, register map
// and the word rotations. Used by every module of the core; depends on nothing.
package spk48_pkg;

   localparam int WORD_W     = 24;
   localparam int SPK_ROUNDS = 22;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic     op;
      word_type word_x_in;
      word_type word_y_in;
   } req_payload_type;

   typedef struct packed {
      word_type word_x_out;
      word_type word_y_out;
   } rsp_payload_type;

   typedef struct packed {
      logic     op;
      word_type x;
      word_type y;
   } stage_data_type;

   typedef enum logic [1:0] {
      REG_KEY_L1 = 2'd0,
      REG_KEY_L0 = 2'd1,
      REG_KEY_K0 = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   function automatic word_type ror8(input word_type v);
      return {v[7:0], v[WORD_W-1:8]};
   endfunction

   function automatic word_type rol8(input word_type v);
      return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
   endfunction

   function automatic word_type rol3(input word_type v);
      return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
   endfunction

   function automatic word_type ror3(input word_type v);
      return {v[2:0], v[WORD_W-1:3]};
   endfunction

endpackage

### hdl/speck48_72_block_cipher_core.sv
// Top level of the Speck48/72 block cipher core: key registers, key expander
// and round pipeline. Depends on spk48_pkg, spk48_key_sched and spk48_round.
//
// Usage: the three 24-bit key words are written over the csr_ port at byte
// addresses 0 (l1), 4 (l0) and 8 (k0) while the core is idle. Each block
// enters on the req_ channel with an encrypt or decrypt selector and leaves
// on the rsp_ channel; a transfer takes place at a clock edge with valid high
// and stall low. The pipeline holds one round per stage, ROUNDS stages deep,
// and a block passes the stage registers in order; rsp_valid rises when it
// reaches the last one. One block is taken every cycle while req_stall is
// low. The last stage register is the output register.
// After reset and after every key write the expander steps the key schedule
// once per cycle; req_stall stays high while it runs.
// When rsp_stall is high the result holds and empty stages keep filling,
// so back-pressure raises req_stall only once every stage holds a block.
// Reset clears the key words to zero and empties the pipeline.
module speck48_72_block_cipher_core #(
   parameter int ROUNDS = spk48_pkg::SPK_ROUNDS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  spk48_pkg::req_payload_type        req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output spk48_pkg::rsp_payload_type        rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [spk48_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [spk48_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [spk48_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import spk48_pkg::*;

   word_type                      key_l1_ff;
   word_type                      key_l0_ff;
   word_type                      key_k0_ff;
   logic                          csr_write;
   reg_index_type                 csr_index;
   logic                          sched_busy;
   logic [ROUNDS-1:0][WORD_W-1:0] round_keys;
   logic [ROUNDS:0]               stage_ready;
   logic [ROUNDS-1:0]             stage_valid;
   stage_data_type                stage_data [ROUNDS];
   stage_data_type                req_stage;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_l1_ff <= '0;
         key_l0_ff <= '0;
         key_k0_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_KEY_L1: key_l1_ff <= csr_pwdata[WORD_W-1:0];
            REG_KEY_L0: key_l0_ff <= csr_pwdata[WORD_W-1:0];
            REG_KEY_K0: key_k0_ff <= csr_pwdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY_L1: csr_prdata = CSR_DATA_W'(key_l1_ff);
         REG_KEY_L0: csr_prdata = CSR_DATA_W'(key_l0_ff);
         REG_KEY_K0: csr_prdata = CSR_DATA_W'(key_k0_ff);
         default:    csr_prdata = '0;
      endcase
   end

   spk48_key_sched #(
      .ROUNDS(ROUNDS)
   ) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .key_l1     (key_l1_ff),
      .key_l0     (key_l0_ff),
      .key_k0     (key_k0_ff),
      .busy       (sched_busy),
      .round_keys (round_keys)
   );

   assign req_stage.op = req_payload.op;
   assign req_stage.x  = req_payload.word_x_in;
   assign req_stage.y  = req_payload.word_y_in;

   assign stage_ready[ROUNDS] = !rsp_stall;
   assign req_stall           = !stage_ready[0] || sched_busy;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_stage
      logic           valid_in;
      stage_data_type data_in;

      if (r == 0) begin : g_first
         assign valid_in = req_valid && !req_stall;
         assign data_in  = req_stage;
      end else begin : g_next
         assign valid_in = stage_valid[r-1];
         assign data_in  = stage_data[r-1];
      end

      assign stage_ready[r] = !stage_valid[r] || stage_ready[r+1];

      spk48_round u_round (
         .clock     (clock),
         .reset     (reset),
         .load      (stage_ready[r]),
         .valid_in  (valid_in),
         .data_in   (data_in),
         .key_enc   (round_keys[r]),
         .key_dec   (round_keys[ROUNDS-1-r]),
         .valid_out (stage_valid[r]),
         .data_out  (stage_data[r])
      );
   end

   assign rsp_valid              = stage_valid[ROUNDS-1];
   assign rsp_payload.word_x_out = stage_data[ROUNDS-1].x;
   assign rsp_payload.word_y_out = stage_data[ROUNDS-1].y;

endmodule

### hdl/spk48_key_sched.sv
// Round key expander of the Speck48/72 core: one schedule step per cycle
// into a bank of round key registers. Depends on spk48_pkg.
module spk48_key_sched #(
   parameter int ROUNDS = spk48_pkg::SPK_ROUNDS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  restart,
   input  spk48_pkg::word_type                   key_l1,
   input  spk48_pkg::word_type                   key_l0,
   input  spk48_pkg::word_type                   key_k0,
   output logic                                  busy,
   output logic [ROUNDS-1:0][spk48_pkg::WORD_W-1:0] round_keys
);
   import spk48_pkg::*;

   localparam int IDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   logic                         start_ff;
   logic                         run_ff;
   logic [IDX_W-1:0]             idx_ff;
   word_type                     k_ff;
   word_type                     a_ff;
   word_type                     b_ff;
   logic [ROUNDS-1:0][WORD_W-1:0] keys_ff;
   word_type                     t_in;
   word_type                     k_in;

   assign t_in = (ror8(a_ff) + k_ff) ^ WORD_W'(idx_ff);
   assign k_in = rol3(k_ff) ^ t_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         run_ff   <= 1'b0;
      end else if (restart) begin
         start_ff <= 1'b1;
         run_ff   <= 1'b0;
      end else if (start_ff) begin
         start_ff <= 1'b0;
         run_ff   <= (ROUNDS > 1);
      end else if (run_ff && idx_ff == IDX_W'(ROUNDS - 2)) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start_ff) begin
         idx_ff     <= '0;
         k_ff       <= key_k0;
         a_ff       <= key_l0;
         b_ff       <= key_l1;
         keys_ff[0] <= key_k0;
      end else if (run_ff) begin
         idx_ff                 <= idx_ff + 1'b1;
         k_ff                   <= k_in;
         a_ff                   <= b_ff;
         b_ff                   <= t_in;
         keys_ff[idx_ff + 1'b1] <= k_in;
      end
   end

   assign busy       = start_ff | run_ff;
   assign round_keys = keys_ff;

endmodule

### hdl/spk48_round.sv
// One pipeline stage of the Speck48/72 core: a single encryption or
// decryption round followed by the stage register. Depends on spk48_pkg.
module spk48_round (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      valid_in,
   input  spk48_pkg::stage_data_type data_in,
   input  spk48_pkg::word_type       key_enc,
   input  spk48_pkg::word_type       key_dec,
   output logic                      valid_out,
   output spk48_pkg::stage_data_type data_out
);
   import spk48_pkg::*;

   logic           valid_ff;
   stage_data_type data_ff;
   stage_data_type data_in_next;
   word_type       enc_x;
   word_type       dec_y;

   always_comb begin
      enc_x              = (ror8(data_in.x) + data_in.y) ^ key_enc;
      dec_y              = ror3(data_in.y ^ data_in.x);
      data_in_next.op    = data_in.op;
      if (data_in.op == OP_DECRYPT) begin
         data_in_next.y = dec_y;
         data_in_next.x = rol8((data_in.x ^ key_dec) - dec_y);
      end else begin
         data_in_next.x = enc_x;
         data_in_next.y = rol3(data_in.y) ^ enc_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

### hdl/spk48_checker.sv
// Port-level assertions for the Speck48/72 core and the bind that attaches
// them. Depends on spk48_pkg, assert_macros.svh and the top level.
`include "assert_macros.svh"

module spk48_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input spk48_pkg::rsp_payload_type        rsp_payload,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic                              csr_pready
);
   import spk48_pkg::*;

   logic csr_write;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // A stalled result stays valid and unchanged.
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // A key write restarts the schedule, which blocks new input.
   `ASSERT_CLK(a_key_write_stall, csr_write |=> req_stall, "input open right after a key write")

   // Reset empties the pipeline and starts the key schedule.
   `ASSERT_CLK_ALWAYS(a_reset_stall, reset |=> req_stall, "input open right after reset")
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind speck48_72_block_cipher_core spk48_checker u_spk48_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_pready  (csr_pready)
);

### bench/spk48_block_checker.sv
// Checker for the Speck48/72 core: follows key register writes, predicts the
// output block of every accepted input and compares results in order.
// Depends on spk48_pkg for the payload types, word width and register map.
module spk48_block_checker
   import spk48_pkg::*;
#(
   parameter int ROUNDS = SPK_ROUNDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int                     error_count,
   output int                     pending_count
);

   word_type key_l1 = '0;
   word_type key_l0 = '0;
   word_type key_k0 = '0;
   rsp_payload_type expected_blocks[$];

   function automatic word_type rotate_left(input word_type v, input int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic word_type rotate_right(input word_type v, input int n);
      return rotate_left(v, WORD_W - n);
   endfunction

   function automatic rsp_payload_type cipher_block(input req_payload_type blk);
      word_type round_key [ROUNDS];
      word_type k, a, b, t, x, y;
      rsp_payload_type result;
      k = key_k0;
      a = key_l0;
      b = key_l1;
      round_key[0] = k;
      for (int i = 0; i < ROUNDS - 1; i++) begin
         t = (rotate_right(a, 8) + k) ^ word_type'(i);
         k = rotate_left(k, 3) ^ t;
         a = b;
         b = t;
         round_key[i + 1] = k;
      end
      x = blk.word_x_in;
      y = blk.word_y_in;
      if (blk.op == OP_ENCRYPT) begin
         for (int r = 0; r < ROUNDS; r++) begin
            x = (rotate_right(x, 8) + y) ^ round_key[r];
            y = rotate_left(y, 3) ^ x;
         end
      end else begin
         for (int r = ROUNDS - 1; r >= 0; r--) begin
            y = rotate_right(y ^ x, 3);
            x = rotate_left((x ^ round_key[r]) - y, 8);
         end
      end
      result.word_x_out = x;
      result.word_y_out = y;
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      int fails;
      fails = 0;
      if (reset) begin
         key_l1 = '0;
         key_l0 = '0;
         key_k0 = '0;
         expected_blocks.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_KEY_L1: key_l1 = csr_pwdata[WORD_W-1:0];
               REG_KEY_L0: key_l0 = csr_pwdata[WORD_W-1:0];
               REG_KEY_K0: key_k0 = csr_pwdata[WORD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: result transfer with nothing expected, x=%06h y=%06h",
                        $time, rsp_payload.word_x_out, rsp_payload.word_y_out);
               fails++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_payload.word_x_out !== want.word_x_out) begin
                  $display("%0t: word_x_out expected %06h, got %06h",
                           $time, want.word_x_out, rsp_payload.word_x_out);
                  fails++;
               end
               if (rsp_payload.word_y_out !== want.word_y_out) begin
                  $display("%0t: word_y_out expected %06h, got %06h",
                           $time, want.word_y_out, rsp_payload.word_y_out);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_blocks.push_back(cipher_block(req_payload));
         end
         error_count <= error_count + fails;
         pending_count <= expected_blocks.size();
      end
   end

endmodule

### bench/tb_speck48_72_block_cipher_core.sv
// Testbench top for the Speck48/72 core: clock, reset, key writes and block
// traffic with random gaps and stalls. Depends on spk48_pkg, the core and
// spk48_block_checker, which does all prediction and comparison.
module tb_speck48_72_block_cipher_core;
   import spk48_pkg::*;

   localparam int ROUNDS      = SPK_ROUNDS;
   localparam int HOLD_CYCLES = 4 * ROUNDS;
   localparam int CYCLE_LIMIT = 300000;

   localparam word_type CORNER_X [5] = '{24'h000000, 24'hffffff, 24'h000000,
                                         24'hffffff, 24'haaaaaa};
   localparam word_type CORNER_Y [5] = '{24'h000000, 24'hffffff, 24'hffffff,
                                         24'h000000, 24'h555555};

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int   error_count;
   int   pending_count;
   int   req_idle_pct   = 30;
   int   rsp_idle_pct   = 30;
   logic rsp_hold_start = 1'b0;
   int   rsp_hold_left  = 0;

   speck48_72_block_cipher_core #(.ROUNDS(ROUNDS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   spk48_block_checker #(.ROUNDS(ROUNDS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, or for a long counted stretch on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_hold_start) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic word_type random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic send_block(input logic op, input word_type x, input word_type y);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= '{op: op, word_x_in: x, word_y_in: y};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random_blocks(input int count);
      repeat (count) begin
         send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT,
                    random_word(), random_word());
      end
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (ROUNDS + 4) @(posedge clock);
   endtask

   task automatic write_key(input reg_index_type idx, input word_type value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[WORD_W-1:0] = value;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_keys(input word_type l1, input word_type l0, input word_type k0);
      write_key(REG_KEY_L1, l1);
      write_key(REG_KEY_L0, l0);
      write_key(REG_KEY_K0, k0);
   endtask

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[speck48_72_block_cipher_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Corner blocks under the all-zero key left by reset, in both directions.
      foreach (CORNER_X[i]) begin
         send_block(OP_ENCRYPT, CORNER_X[i], CORNER_Y[i]);
         send_block(OP_DECRYPT, CORNER_X[i], CORNER_Y[i]);
      end
      wait_for_idle();

      // Published key and block, then a write to the unused address, which
      // must leave the key unchanged.
      write_keys(24'h1a1918, 24'h121110, 24'h0a0908);
      send_block(OP_ENCRYPT, 24'h6d2073, 24'h696874);
      send_block(OP_DECRYPT, 24'h735e10, 24'hb6445d);
      wait_for_idle();
      write_key(REG_NONE, random_word());
      send_block(OP_ENCRYPT, 24'h6d2073, 24'h696874);
      send_block(OP_DECRYPT, 24'h735e10, 24'hb6445d);
      wait_for_idle();

      write_keys('1, '1, '1);
      send_random_blocks(100);

      for (int phase = 0; phase < 7; phase++) begin
         wait_for_idle();
         if (phase == 5) begin
            write_key(REG_KEY_K0, '0);
            write_key(REG_NONE, random_word());
         end else begin
            write_keys(random_word(), random_word(), random_word());
         end
         if (phase == 1) begin
            req_idle_pct = 0;
            rsp_idle_pct <= 0;
         end else begin
            req_idle_pct = 30;
            rsp_idle_pct <= 30;
         end
         if (phase == 3) begin
            req_idle_pct = 0;
            rsp_hold_start <= 1'b1;
            @(posedge clock);
            rsp_hold_start <= 1'b0;
            send_random_blocks(60);
            req_idle_pct = 30;
            send_random_blocks(60);
         end else begin
            send_random_blocks(120);
         end
      end

      wait_for_idle();
      if (error_count == 0 && pending_count == 0) begin
         $display("[speck48_72_block_cipher_core] OK");
      end else begin
         $display("[speck48_72_block_cipher_core] ERROR");
      end
      $finish;
   end

endmodule
